/* rtl/fbr_pkg.sv */
// Shared types, command and status codes for the framed byte ring.
package fbr_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 10;
    localparam int OUT_W    = 11;
    localparam int HDR_BYTES = 2;

    // Stream word layouts
    localparam int IN_DATA_W     = 32;
    localparam int IN_BYTE_LSB   = 0;
    localparam int IN_FLEN_LSB   = IN_BYTE_LSB + BYTE_W;
    localparam int IN_MLEN_LSB   = IN_FLEN_LSB + LEN_W;
    localparam int OUT_DATA_W    = 48;
    localparam int OUT_BYTE_LSB  = 0;
    localparam int OUT_DROP_LSB  = OUT_BYTE_LSB + BYTE_W;
    localparam int OUT_AVAIL_LSB = OUT_DROP_LSB + OUT_W;
    localparam int OUT_FREE_LSB  = OUT_AVAIL_LSB + OUT_W;
    localparam int OUT_USED_W    = OUT_FREE_LSB + OUT_W;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd255;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUSH_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BYTE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PKT_READ    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STREAM_READ = 2'd3;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER_MAX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_PUSH = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   read_byte;
        logic                last_of_frame;
        logic [OUT_W-1:0]    dropped_bytes;
        logic [OUT_W-1:0]    stream_avail;
        logic [OUT_W-1:0]    free_space;
    } t_result;

endpackage

/* rtl/fbr_out_stage.sv */
// Output register that holds one result word until the sink takes it.
module fbr_out_stage import fbr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Hold the word until taken; the user must load only when empty or draining, the stage does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (r_valid && i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/framed_byte_ring_drop_oldest.sv */
// Top level: length-prefixed frame ring with drop-oldest admission.
//
// The ring stores frames as a two-byte little-endian length followed by the
// payload, in one byte-wide synchronous memory with one write and one read
// port. Commands arrive one at a time on the input stream (tuser selects
// push start, push byte, packet read or stream read) and each gives exactly
// one result word. A push byte, or a read that continues an open frame,
// takes one memory access before its result. A read that opens a frame
// first fetches the header, and a stream read fetches one more header for
// every empty frame it skips. A push start writes the header once the frame
// fits; each complete frame dropped to make room adds a header fetch and a
// move of the R bytes still unread in the open frame up over the dropped one,
// and the open frame is discarded if it alone is left. The ring needs no
// initialization after reset. The user must write max_frame_len on the cfg
// channel only while no command is in flight; the block does not enforce it.
module framed_byte_ring_drop_oldest import fbr_pkg::*; #(
    parameter int RING_BYTES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: data_byte[7:0], frame_len[17:8], max_len[27:18], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: read_byte[7:0], dropped_bytes[18:8], stream_avail[29:19],
    //        free_space[40:30], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [STATUS_W-1:0]   m_axis_tuser,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LEN_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(RING_BYTES);
    localparam int CW = $clog2(RING_BYTES + 1);
    localparam int SW = ((CW > LEN_W + 1) ? CW : LEN_W + 1) + 1;
    localparam logic [SW-1:0] RING_S = SW'(RING_BYTES);
    localparam logic [AW-1:0] LAST_PTR = AW'(RING_BYTES - 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DONE      = 4'd1;
    localparam logic [3:0] S_HDR_HI    = 4'd2;
    localparam logic [3:0] S_HDR_USE   = 4'd3;
    localparam logic [3:0] S_FIT       = 4'd4;
    localparam logic [3:0] S_HDR_W1    = 4'd5;
    localparam logic [3:0] S_MOVE_SET  = 4'd6;
    localparam logic [3:0] S_MOVE      = 4'd7;
    localparam logic [3:0] S_DROP_FIN  = 4'd8;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                               input logic [SW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(p) + off;
        if (s >= RING_S) begin
            s = s - RING_S;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] p);
        return (p == '0) ? LAST_PTR : p - 1'b1;
    endfunction

    function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] v);
        return (v == '0) ? '0 : v - 1'b1;
    endfunction

    function automatic logic [CW-1:0] sub_clamp(input logic [CW-1:0] a,
                                                input logic [SW-1:0] b);
        logic [SW-1:0] d;
        d = SW'(a) - b;
        return (SW'(a) >= b) ? d[CW-1:0] : '0;
    endfunction

    function automatic logic [OUT_W-1:0] cnt_out(input logic [CW-1:0] v);
        logic [CW+OUT_W-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        return w[OUT_W-1:0];
    endfunction

    // Input word fields
    logic [CMD_W-1:0]  in_cmd;
    logic [BYTE_W-1:0] in_byte;
    logic [LEN_W-1:0]  in_flen;
    logic [LEN_W-1:0]  in_mlen;
    logic              in_accept;

    assign in_cmd    = s_axis_tuser;
    assign in_byte   = s_axis_tdata[IN_BYTE_LSB +: BYTE_W];
    assign in_flen   = s_axis_tdata[IN_FLEN_LSB +: LEN_W];
    assign in_mlen   = s_axis_tdata[IN_MLEN_LSB +: LEN_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Control state
    logic [3:0]       r_state, n_state;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]    r_used, n_used;
    logic [CW-1:0]    r_avail, n_avail;
    logic [LEN_W-1:0] r_push_rem, n_push_rem;
    logic [LEN_W-1:0] r_rd_rem, n_rd_rem;
    logic [LEN_W-1:0] r_max_len;
    logic             r_wpend, n_wpend;

    // Per-command working registers
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [LEN_W-1:0]    r_flen, n_flen;
    logic [LEN_W-1:0]    r_mlen, n_mlen;
    logic [LEN_W-1:0]    r_push_len, n_push_len;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_last, n_last;
    logic                r_take, n_take;
    logic [OUT_W-1:0]    r_dropped, n_dropped;
    logic [AW-1:0]       r_hdr_addr, n_hdr_addr;
    logic [BYTE_W-1:0]   r_lo, n_lo;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [AW-1:0]       r_src, n_src;
    logic [AW-1:0]       r_dst, n_dst;
    logic [LEN_W-1:0]    r_cnt, n_cnt;

    // Ring memory
    logic [BYTE_W-1:0] r_ring [RING_BYTES];
    logic [BYTE_W-1:0] r_mem_q;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_wa, mem_ra;
    logic [BYTE_W-1:0] mem_wd;

    // Result path
    logic    out_valid, out_load;
    t_result out_next, out_word;

    // Derived values
    logic [LEN_W-1:0] hdr_len;
    logic [SW-1:0]    hdr_span, len_span, need, taken, free_sw;
    logic [CW-1:0]    used_open;
    logic [AW-1:0]    ptr_open;

    assign hdr_len   = {r_mem_q[LEN_W-BYTE_W-1:0], r_lo};
    assign hdr_span  = SW'(hdr_len) + SW'(HDR_BYTES);
    assign len_span  = SW'(r_len) + SW'(HDR_BYTES);
    assign need      = SW'(r_flen) + SW'(HDR_BYTES);
    assign used_open = sub_clamp(r_used, SW'(HDR_BYTES));
    assign ptr_open  = wrap_add(r_rd_ptr, SW'(HDR_BYTES));
    assign taken     = SW'(r_used) +
                       ((r_push_rem != '0) ? SW'(r_push_len) + SW'(HDR_BYTES) : '0);
    assign free_sw   = (taken >= RING_S) ? '0 : RING_S - taken;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // Sequencer: one command at a time through the memory
    always_comb begin
        n_state    = r_state;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_used     = r_used;
        n_avail    = r_avail;
        n_push_rem = r_push_rem;
        n_rd_rem   = r_rd_rem;
        n_wpend    = r_wpend;
        n_cmd      = r_cmd;
        n_flen     = r_flen;
        n_mlen     = r_mlen;
        n_push_len = r_push_len;
        n_status   = r_status;
        n_last     = r_last;
        n_take     = r_take;
        n_dropped  = r_dropped;
        n_hdr_addr = r_hdr_addr;
        n_lo       = r_lo;
        n_len      = r_len;
        n_src      = r_src;
        n_dst      = r_dst;
        n_cnt      = r_cnt;
        mem_we     = 1'b0;
        mem_wa     = r_wr_ptr;
        mem_wd     = in_byte;
        mem_re     = 1'b0;
        mem_ra     = r_rd_ptr;
        out_load   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd     = in_cmd;
                    n_flen    = in_flen;
                    n_mlen    = in_mlen;
                    n_status  = ST_OK;
                    n_last    = 1'b0;
                    n_take    = 1'b0;
                    n_dropped = '0;
                    n_state   = S_DONE;
                    case (in_cmd)
                        CMD_PUSH_START: begin
                            // Abandon any unfinished push, restart at commit end
                            n_wr_ptr   = wrap_add(r_rd_ptr, SW'(r_used));
                            n_push_rem = '0;
                            if (in_flen > r_max_len ||
                                SW'(in_flen) + SW'(HDR_BYTES) > RING_S) begin
                                n_status = ST_REJECT;
                            end else begin
                                n_state = S_FIT;
                            end
                        end
                        CMD_PUSH_BYTE: begin
                            if (r_push_rem == '0) begin
                                n_status = ST_BAD_PUSH;
                            end else begin
                                mem_we     = 1'b1;
                                mem_wa     = r_wr_ptr;
                                mem_wd     = in_byte;
                                n_wr_ptr   = wrap_add(r_wr_ptr, SW'(1));
                                n_push_rem = r_push_rem - 1'b1;
                                // Commit the frame on its last byte
                                if (r_push_rem == LEN_W'(1)) begin
                                    n_used  = CW'(SW'(r_used) + SW'(r_push_len) +
                                                  SW'(HDR_BYTES));
                                    n_avail = CW'(SW'(r_avail) + SW'(r_push_len));
                                end
                            end
                        end
                        default: begin
                            if (r_rd_rem != '0) begin
                                // Continue the open frame
                                mem_re   = 1'b1;
                                mem_ra   = r_rd_ptr;
                                n_rd_ptr = wrap_add(r_rd_ptr, SW'(1));
                                n_used   = dec_sat(r_used);
                                n_avail  = dec_sat(r_avail);
                                n_rd_rem = r_rd_rem - 1'b1;
                                n_last   = (r_rd_rem == LEN_W'(1));
                                n_take   = 1'b1;
                            end else if (r_used != '0) begin
                                // Fetch the next frame header
                                mem_re     = 1'b1;
                                mem_ra     = r_rd_ptr;
                                n_hdr_addr = r_rd_ptr;
                                n_state    = S_HDR_HI;
                            end else begin
                                n_status = ST_EMPTY;
                            end
                        end
                    endcase
                end
            end

            S_HDR_HI: begin
                mem_re  = 1'b1;
                mem_ra  = wrap_add(r_hdr_addr, SW'(1));
                n_lo    = r_mem_q;
                n_state = S_HDR_USE;
            end

            S_HDR_USE: begin
                if (r_cmd == CMD_PUSH_START) begin
                    n_len   = hdr_len;
                    n_state = S_MOVE_SET;
                end else if (r_cmd == CMD_PKT_READ && hdr_len > r_mlen) begin
                    // Skip the whole oversized frame
                    n_rd_ptr = wrap_add(r_rd_ptr, hdr_span);
                    n_used   = sub_clamp(r_used, hdr_span);
                    n_avail  = sub_clamp(r_avail, SW'(hdr_len));
                    n_status = ST_OVER_MAX;
                    n_state  = S_DONE;
                end else if (hdr_len == '0) begin
                    // Consume an empty frame
                    n_rd_ptr = ptr_open;
                    n_used   = used_open;
                    n_rd_rem = '0;
                    if (r_cmd == CMD_STREAM_READ && used_open != '0) begin
                        mem_re     = 1'b1;
                        mem_ra     = ptr_open;
                        n_hdr_addr = ptr_open;
                        n_state    = S_HDR_HI;
                    end else begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end
                end else begin
                    // Open the frame and take its first byte
                    mem_re   = 1'b1;
                    mem_ra   = ptr_open;
                    n_rd_ptr = wrap_add(r_rd_ptr, SW'(HDR_BYTES + 1));
                    n_used   = dec_sat(used_open);
                    n_avail  = dec_sat(r_avail);
                    n_rd_rem = hdr_len - 1'b1;
                    n_last   = (hdr_len == LEN_W'(1));
                    n_take   = 1'b1;
                    n_state  = S_DONE;
                end
            end

            S_FIT: begin
                if (SW'(r_used) + need <= RING_S) begin
                    // Room found: write the header low byte
                    mem_we  = 1'b1;
                    mem_wa  = r_wr_ptr;
                    mem_wd  = r_flen[BYTE_W-1:0];
                    n_state = S_HDR_W1;
                end else if (SW'(r_used) > SW'(r_rd_rem)) begin
                    // Drop the first complete frame after the open one
                    n_hdr_addr = wrap_add(r_rd_ptr, SW'(r_rd_rem));
                    mem_re     = 1'b1;
                    mem_ra     = wrap_add(r_rd_ptr, SW'(r_rd_rem));
                    n_state    = S_HDR_HI;
                end else begin
                    // Only the open frame is left: discard it
                    n_dropped = r_dropped + OUT_W'(r_rd_rem);
                    n_rd_ptr  = r_wr_ptr;
                    n_used    = '0;
                    n_rd_rem  = '0;
                    n_avail   = '0;
                end
            end

            S_HDR_W1: begin
                mem_we     = 1'b1;
                mem_wa     = wrap_add(r_wr_ptr, SW'(1));
                mem_wd     = BYTE_W'(r_flen >> BYTE_W);
                n_wr_ptr   = wrap_add(r_wr_ptr, SW'(HDR_BYTES));
                n_push_rem = r_flen;
                n_push_len = r_flen;
                if (r_flen == '0) begin
                    n_used = CW'(SW'(r_used) + SW'(HDR_BYTES));
                end
                n_state = S_DONE;
            end

            S_MOVE_SET: begin
                if (r_rd_rem == '0) begin
                    n_state = S_DROP_FIN;
                end else begin
                    n_src   = wrap_add(r_rd_ptr, SW'(r_rd_rem) - SW'(1));
                    n_dst   = wrap_add(r_rd_ptr, SW'(r_rd_rem) - SW'(1) + len_span);
                    n_cnt   = r_rd_rem;
                    n_wpend = 1'b0;
                    n_state = S_MOVE;
                end
            end

            S_MOVE: begin
                // Shift the open frame up, highest byte first
                if (r_wpend) begin
                    mem_we = 1'b1;
                    mem_wa = r_dst;
                    mem_wd = r_mem_q;
                    n_dst  = dec_ptr(r_dst);
                end
                if (r_cnt != '0) begin
                    mem_re  = 1'b1;
                    mem_ra  = r_src;
                    n_src   = dec_ptr(r_src);
                    n_cnt   = r_cnt - 1'b1;
                    n_wpend = 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    n_state = S_DROP_FIN;
                end
            end

            S_DROP_FIN: begin
                n_rd_ptr  = wrap_add(r_rd_ptr, len_span);
                n_used    = sub_clamp(r_used, len_span);
                n_avail   = sub_clamp(r_avail, SW'(r_len));
                n_dropped = r_dropped + OUT_W'(r_len);
                n_state   = S_FIT;
            end

            S_DONE: begin
                if (!out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_used     <= '0;
            r_avail    <= '0;
            r_push_rem <= '0;
            r_rd_rem   <= '0;
            r_wpend    <= 1'b0;
            r_max_len  <= MAX_LEN_RESET;
        end else begin
            r_state    <= n_state;
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_used     <= n_used;
            r_avail    <= n_avail;
            r_push_rem <= n_push_rem;
            r_rd_rem   <= n_rd_rem;
            r_wpend    <= n_wpend;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_flen     <= n_flen;
        r_mlen     <= n_mlen;
        r_push_len <= n_push_len;
        r_status   <= n_status;
        r_last     <= n_last;
        r_take     <= n_take;
        r_dropped  <= n_dropped;
        r_hdr_addr <= n_hdr_addr;
        r_lo       <= n_lo;
        r_len      <= n_len;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_cnt      <= n_cnt;
    end

    // Ring memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_ring[mem_ra];
        end
    end

    // Assemble the result word
    always_comb begin
        out_next.status        = r_status;
        out_next.read_byte     = r_take ? r_mem_q : '0;
        out_next.last_of_frame = r_last;
        out_next.dropped_bytes = r_dropped;
        out_next.stream_avail  = cnt_out(r_avail);
        out_next.free_space    = free_sw[OUT_W-1:0];
    end

    fbr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (out_next),
        .i_ready  (m_axis_tready),
        .o_valid  (out_valid),
        .o_result (out_word)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_word.status;
    assign m_axis_tlast  = out_word.last_of_frame;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                            out_word.free_space,
                            out_word.stream_avail,
                            out_word.dropped_bytes,
                            out_word.read_byte};

endmodule

/* rtl/fbr_port_chk.sv */
// Port-level checks for the framed byte ring, bound to the top level.
module fbr_port_chk import fbr_pkg::*; #(
    parameter int RING_BYTES = 1024
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [CMD_W-1:0]      s_axis_tuser,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]   m_axis_tuser,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [LEN_W-1:0]      i_cfg_data
);

    logic [OUT_W:0] avail_plus_free;

    assign avail_plus_free = {1'b0, m_axis_tdata[OUT_AVAIL_LSB +: OUT_W]} +
                             {1'b0, m_axis_tdata[OUT_FREE_LSB +: OUT_W]};

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // One command in flight: no word accepted right after another
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a command was in flight");

    // A failed command delivers no byte
    a_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |->
            !m_axis_tlast && m_axis_tdata[OUT_BYTE_LSB +: BYTE_W] == '0)
        else $error("byte delivered with a failing status");

    // Drops only come from an admitted push start
    a_drop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_DROP_LSB +: OUT_W] != '0 |->
            m_axis_tuser == ST_OK && !m_axis_tlast)
        else $error("dropped bytes reported outside a push start");

    // Readable bytes and free space never exceed the ring (checked for rings up to 2047 bytes)
    a_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (RING_BYTES > 2047) || (int'(avail_plus_free) <= RING_BYTES))
        else $error("stream_avail plus free_space exceeds ring size");

endmodule

bind framed_byte_ring_drop_oldest fbr_port_chk #(.RING_BYTES(RING_BYTES)) u_port_chk (.*);
